FILE: rtl/cfp_pkg.sv
// Package for the credit flow packetizer: shared types, codes and constants.
// It depends on nothing; every other file but cfp_stream_if and cfp_ram imports it.
package cfp_pkg;

    // Default depth of the message size queue (top level parameter default).
    localparam int QUEUE_DEPTH_DEF = 16;
    // Header bits carried by every packet.
    localparam int HEADER_BITS = 64;

    localparam int SIZE_W   = 20;  // message size and bits remaining
    localparam int PKT_W    = 16;  // packet size, max packet size, sequence
    localparam int CREDIT_W = 11;  // buffer width, buffer depth, credits
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_CREDIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_DEPTH = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [PKT_W-1:0]    MAX_PACKET_RST   = 16'd1024;
    localparam logic [CREDIT_W-1:0] BUFFER_WIDTH_RST = 11'd64;
    localparam logic [CREDIT_W-1:0] BUFFER_DEPTH_RST = 11'd16;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SIZE_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic                packet_valid;
        logic [PKT_W-1:0]    packet_size;
        logic [PKT_W-1:0]    sequence_number;
        logic                last_packet;
        logic                message_retired;
        logic                push_dropped;
        logic [CREDIT_W-1:0] credits_left;
    } t_out_item;

    // A classified command as the front end hands it to the back end.
    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [SIZE_W-1:0] amount;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

    typedef struct packed {
        logic [PKT_W-1:0]    max_packet_size;
        logic [CREDIT_W-1:0] buffer_width;
        logic [CREDIT_W-1:0] buffer_depth;
    } t_cfg;

endpackage

FILE: rtl/cfp_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; the block uses the item types of cfp_pkg.
interface cfp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/credit_flow_packetizer_top.sv
// Top level of the credit flow packetizer: configuration registers and the
// front and back ends. Depends on cfp_pkg, cfp_stream_if, cfp_front, cfp_back.
//
// The packetizer is the sending side of a network interface. Each input item
// carries an operation and an amount: a push queues a message size (dropped
// and flagged when the queue is full), a credit return adds credits that
// saturate at buffer_depth, and a service step pops the next message when
// none is active, cuts one packet of min(max packet, remaining + header) bits
// when ceil(packet / buffer_width) credits are free, or retires a finished
// message. Every item gives exactly one result item. Pushes, credit returns,
// unused codes and a service step with an empty queue offer their result once
// the back end has taken the command and loaded the output register. A
// service step that retires a message also passes the sizing state, and the
// queue read state before it when it also pops the message. A service step
// that sizes a packet passes through these steps: the back end takes the
// command, sizes the packet, runs a restoring divider that produces one
// quotient bit per cycle over the 16-bit packet size, checks and takes the
// credits and loads the result register, with a queue read before the
// sizing on a pop. A stalled receiver adds its stall cycles on top. A
// two-entry command queue in the front end takes new items while the back
// end works, and the output register holds a finished result while the
// next item is already started.
// Configuration writes take effect at once and are meant for idle periods;
// the message queue needs no clearing pass after reset.
module credit_flow_packetizer_top #(
    parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfp_stream_if.sink                       i_cmd,
    cfp_stream_if.source                     o_res,
    input  logic                             i_cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cfp_pkg::*;

    t_cfg     r_cfg;
    t_cmd_req req;
    logic     req_ready;

    // Configuration registers. A write to an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_packet_size <= MAX_PACKET_RST;
            r_cfg.buffer_width    <= BUFFER_WIDTH_RST;
            r_cfg.buffer_depth    <= BUFFER_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PACKET:   r_cfg.max_packet_size <= i_cfg_data;
                CFG_BUFFER_WIDTH: r_cfg.buffer_width    <= i_cfg_data[CREDIT_W-1:0];
                CFG_BUFFER_DEPTH: r_cfg.buffer_depth    <= i_cfg_data[CREDIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end decouples item acceptance from the sequencer.
    cfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    // The back end owns the message queue, credits and packet sequencing.
    cfp_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_req_ready (req_ready),
        .i_cfg       (r_cfg),
        .o_res       (o_res)
    );
endmodule

FILE: rtl/cfp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// It depends on nothing.
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/cfp_front.sv
// Front end: accepts input items, classifies them and holds them in a
// two-entry command queue for the back end. Depends on cfp_pkg, cfp_stream_if.
module cfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfp_stream_if.sink        i_cmd,
    output cfp_pkg::t_cmd_req o_req,
    input  logic              i_req_ready
);
    import cfp_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;
    logic       pop;

    // Unused operation codes become a command that only reports credits.
    always_comb begin
        cls.amount = i_cmd.payload.amount;
        unique case (i_cmd.payload.operation)
            OP_PUSH:    cls.kind = OP_PUSH;
            OP_CREDIT:  cls.kind = OP_CREDIT;
            OP_SERVICE: cls.kind = OP_SERVICE;
            default:    cls.kind = OP_NONE;
        endcase
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_req.valid = (r_cnt != 2'd0);
    assign o_req.cmd   = r_slot[r_rd];
    assign pop         = o_req.valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: rtl/cfp_div.sv
// Iterative restoring divider, one quotient bit per cycle, used to turn a
// packet size into a credit count. Depends on cfp_pkg.
module cfp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfp_pkg::PKT_W-1:0]     i_dividend,
    input  logic [cfp_pkg::CREDIT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [cfp_pkg::PKT_W-1:0]     o_quot,
    output logic [cfp_pkg::CREDIT_W-1:0]  o_rem
);
    import cfp_pkg::*;

    localparam int CNT_W = $clog2(PKT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PKT_W-1:0]    r_quot;
    logic [CREDIT_W-1:0] r_rem;
    logic [CREDIT_W-1:0] r_div;
    logic [CREDIT_W:0]   trial;
    logic [CREDIT_W:0]   diff;
    logic                ge;

    // The dividend shifts out of the top of r_quot while quotient bits
    // shift in at the bottom.
    assign trial = {r_rem, r_quot[PKT_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[PKT_W-2:0], ge};
            r_rem  <= ge ? diff[CREDIT_W-1:0] : trial[CREDIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PKT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/cfp_back.sv
// Back end: message size queue, credit counter, packet sequencer and result
// register. Depends on cfp_pkg, cfp_stream_if, cfp_ram and cfp_div.
module cfp_back #(
    parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfp_pkg::t_cmd_req i_req,
    output logic              o_req_ready,
    input  cfp_pkg::t_cfg     i_cfg,
    cfp_stream_if.source      o_res
);
    import cfp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [PKT_W-1:0] HDR    = PKT_W'(HEADER_BITS);
    localparam logic [PKT_W-1:0] HDR_P1 = PKT_W'(HEADER_BITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_SIZE = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_q_head, n_q_head;
    logic [CW-1:0]       r_q_count, n_q_count;
    logic                r_active, n_active;
    logic [SIZE_W-1:0]   r_bits_rem, n_bits_rem;
    logic [PKT_W-1:0]    r_seq, n_seq;
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic [PKT_W-1:0]    r_psize, n_psize;
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       tail;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       head_next;
    logic [SIZE_W-1:0]   ram_rdata;

    logic [PKT_W-1:0]    maxp;
    logic [CREDIT_W-1:0] width_eff;
    logic [SIZE_W:0]     size_sum;
    logic [PKT_W-1:0]    psize_calc;
    logic [SIZE_W:0]     credit_sum;
    logic [CREDIT_W-1:0] credit_sat;
    logic [PKT_W-1:0]    payload_bits;
    logic [SIZE_W-1:0]   bits_rem_next;
    logic [PKT_W:0]      need;
    logic [CREDIT_W-1:0] credit_after;

    logic                div_start;
    logic                div_done;
    logic [PKT_W-1:0]    div_quot;
    logic [CREDIT_W-1:0] div_rem;

    // Queue addressing; the depth need not be a power of two.
    assign tail_sum  = (AW + 1)'(r_q_head) + (AW + 1)'(r_q_count);
    assign tail      = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
    assign head_next = (r_q_head == LAST_IDX) ? '0 : r_q_head + 1'b1;

    cfp_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (i_req.cmd.amount),
        .i_re    (ram_re),
        .i_raddr (r_q_head),
        .o_rdata (ram_rdata)
    );

    // Packet sizing: the effective maximum always leaves one payload bit.
    assign maxp       = (i_cfg.max_packet_size < HDR_P1) ? HDR_P1 : i_cfg.max_packet_size;
    assign width_eff  = (i_cfg.buffer_width == '0) ? CREDIT_W'(1) : i_cfg.buffer_width;
    assign size_sum   = (SIZE_W + 1)'(r_bits_rem) + (SIZE_W + 1)'(HEADER_BITS);
    assign psize_calc = (size_sum > (SIZE_W + 1)'(maxp)) ? maxp : size_sum[PKT_W-1:0];

    assign credit_sum = (SIZE_W + 1)'(r_credit) + (SIZE_W + 1)'(i_req.cmd.amount);
    assign credit_sat = (credit_sum > (SIZE_W + 1)'(i_cfg.buffer_depth)) ?
                        i_cfg.buffer_depth : credit_sum[CREDIT_W-1:0];

    assign payload_bits  = r_psize - HDR;
    assign bits_rem_next = r_bits_rem - SIZE_W'(payload_bits);
    assign need          = (PKT_W + 1)'(div_quot) + (PKT_W + 1)'(div_rem != '0);
    assign credit_after  = r_credit - need[CREDIT_W-1:0];

    assign div_start = (r_state == S_SIZE) && (r_bits_rem != '0);

    cfp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (psize_calc),
        .i_divisor  (width_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_q_head    = r_q_head;
        n_q_count   = r_q_count;
        n_active    = r_active;
        n_bits_rem  = r_bits_rem;
        n_seq       = r_seq;
        n_credit    = r_credit;
        n_psize     = r_psize;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res = '0;
                    n_res.credits_left = r_credit;
                    n_state = S_EMIT;
                    unique case (i_req.cmd.kind)
                        OP_PUSH: begin
                            if (r_q_count >= DEPTH_C) begin
                                n_res.push_dropped = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                n_q_count = r_q_count + 1'b1;
                            end
                        end
                        OP_CREDIT: begin
                            n_credit           = credit_sat;
                            n_res.credits_left = credit_sat;
                        end
                        OP_SERVICE: begin
                            if (!r_active) begin
                                if (r_q_count != '0) begin
                                    ram_re    = 1'b1;
                                    n_q_head  = head_next;
                                    n_q_count = r_q_count - 1'b1;
                                    n_active  = 1'b1;
                                    n_state   = S_POP;
                                end
                            end else begin
                                n_state = S_SIZE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_bits_rem = ram_rdata;
                n_state    = S_SIZE;
            end
            S_SIZE: begin
                if (r_bits_rem == '0) begin
                    n_active              = 1'b0;
                    n_seq                 = '0;
                    n_res.message_retired = 1'b1;
                    n_state               = S_EMIT;
                end else begin
                    n_psize = psize_calc;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (need <= (PKT_W + 1)'(r_credit)) begin
                        n_credit              = credit_after;
                        n_bits_rem            = bits_rem_next;
                        n_seq                 = r_seq + 1'b1;
                        n_res.packet_valid    = 1'b1;
                        n_res.packet_size     = r_psize;
                        n_res.sequence_number = r_seq;
                        n_res.last_packet     = (bits_rem_next == '0);
                        n_res.credits_left    = credit_after;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q_head    <= '0;
            r_q_count   <= '0;
            r_active    <= 1'b0;
            r_bits_rem  <= '0;
            r_seq       <= '0;
            r_credit    <= BUFFER_DEPTH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_q_head    <= n_q_head;
            r_q_count   <= n_q_count;
            r_active    <= n_active;
            r_bits_rem  <= n_bits_rem;
            r_seq       <= n_seq;
            r_credit    <= n_credit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_psize <= n_psize;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= DEPTH_C)
        else $error("message queue count exceeds its depth");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(ram_re))
        else $error("queue data taken without a read in the previous cycle");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || o_res.ready)) |=>
        (r_out_valid && r_state == S_IDLE))
        else $error("pending result was not loaded into the output register");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_packet) |->
        (r_out.packet_valid && !r_out.message_retired))
        else $error("last packet flag without an emitted packet");
endmodule

FILE: test/credit_flow_packetizer_top_tb.sv
// Self-checking testbench for credit_flow_packetizer_top: push, credit, service and
// unused-code items checked against a built-in predictor of queue, credits and packets.
// Depends on cfp_pkg, cfp_stream_if and the packetizer RTL.
module credit_flow_packetizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    // Tracks what the packetizer should do with every accepted item and checks each
    // result against the oldest prediction.
    class packetizer_ledger;
        t_out_item           awaited[$];
        logic [SIZE_W-1:0]   message_sizes[$];
        logic [PKT_W-1:0]    max_packet;
        logic [CREDIT_W-1:0] slot_bits;
        logic [CREDIT_W-1:0] slot_count;
        int unsigned         credits;
        int unsigned         remaining;
        bit                  active;
        logic [PKT_W-1:0]    next_seq;
        int unsigned         commands, packets, retirements, drops, starved, mismatches;

        function new();
            max_packet  = MAX_PACKET_RST;
            slot_bits   = BUFFER_WIDTH_RST;
            slot_count  = BUFFER_DEPTH_RST;
            credits     = BUFFER_DEPTH_RST;
            remaining   = 0;
            active      = 1'b0;
            next_seq    = '0;
            commands    = 0;
            packets     = 0;
            retirements = 0;
            drops       = 0;
            starved     = 0;
            mismatches  = 0;
        endfunction

        // Registers keep only their own width of the data word.
        function void set_link(logic [CFG_DATA_W-1:0] maxp_word, logic [CFG_DATA_W-1:0] width_word,
                               logic [CFG_DATA_W-1:0] depth_word);
            max_packet = maxp_word[PKT_W-1:0];
            slot_bits  = width_word[CREDIT_W-1:0];
            slot_count = depth_word[CREDIT_W-1:0];
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // One controller step of the segmenter for one item.
        function t_out_item segment_step(t_in_item cmd);
            t_out_item   r;
            int unsigned sum, maxp, wid, psize, need;
            r = '0;
            case (cmd.operation)
                OP_PUSH: begin
                    if (message_sizes.size() >= QUEUE_DEPTH_DEF) begin
                        r.push_dropped = 1'b1;
                        drops++;
                    end else begin
                        message_sizes.push_back(cmd.amount);
                    end
                end
                OP_CREDIT: begin
                    sum = credits + cmd.amount;
                    credits = (sum > slot_count) ? slot_count : sum;
                end
                OP_SERVICE: begin
                    if (!active && message_sizes.size() > 0) begin
                        remaining = message_sizes.pop_front();
                        active = 1'b1;
                    end
                    if (active) begin
                        if (remaining == 0) begin
                            // Fully sent (or empty) message: release it and restart numbering.
                            active = 1'b0;
                            next_seq = '0;
                            r.message_retired = 1'b1;
                            retirements++;
                        end else begin
                            maxp  = (max_packet < HEADER_BITS + 1) ? HEADER_BITS + 1 : max_packet;
                            wid   = (slot_bits == 0) ? 1 : slot_bits;
                            psize = remaining + HEADER_BITS;
                            if (psize > maxp) psize = maxp;
                            need = (psize + wid - 1) / wid;
                            if (need <= credits) begin
                                credits   -= need;
                                remaining -= psize - HEADER_BITS;
                                r.packet_valid    = 1'b1;
                                r.packet_size     = psize[PKT_W-1:0];
                                r.sequence_number = next_seq;
                                r.last_packet     = (remaining == 0);
                                next_seq++;
                                packets++;
                            end else begin
                                starved++;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.credits_left = credits[CREDIT_W-1:0];
            return r;
        endfunction

        function void note_command(t_in_item cmd);
            commands++;
            awaited.push_back(segment_step(cmd));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                if (mismatches < 50)
                    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_outcome(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $display("%0t ns: result with no item awaiting it, expected none, got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("packet_valid", want.packet_valid, got.packet_valid);
            compare_field("packet_size", want.packet_size, got.packet_size);
            compare_field("sequence_number", want.sequence_number, got.sequence_number);
            compare_field("last_packet", want.last_packet, got.last_packet);
            compare_field("message_retired", want.message_retired, got.message_retired);
            compare_field("push_dropped", want.push_dropped, got.push_dropped);
            compare_field("credits_left", want.credits_left, got.credits_left);
        endfunction
    endclass

    localparam int LINK_SETTINGS  = 7;
    localparam int ITEMS_PER_LINK = 125;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Percent chances that the sender holds back an item and that the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Idling modes: none, sender only, receiver only, both.
    int idle_modes  [4] = '{0, 57, 0, 35};
    int stall_modes [4] = '{0, 0, 57, 35};

    // Link settings walked through in order. They cover the reset values, the smallest
    // packets with one-bit slots, a maximum below the header with zero slot width (high
    // data bits set so only the register bits count), a setting where large packets can
    // never collect enough credits, the largest packets with wide slots, a depth far below
    // the credits left over from before, and all-ones data words.
    logic [CFG_DATA_W-1:0] maxp_words  [LINK_SETTINGS] =
        '{16'd1024, 16'd65, 16'd0, 16'd512, 16'hFFFF, 16'd64, 16'hFFFF};
    logic [CFG_DATA_W-1:0] width_words [LINK_SETTINGS] =
        '{16'd64, 16'd1, 16'hF800, 16'd8, 16'd1024, 16'hF825, 16'hFFFF};
    logic [CFG_DATA_W-1:0] depth_words [LINK_SETTINGS] =
        '{16'd16, 16'd1024, 16'd70, 16'd32, 16'd1024, 16'd5, 16'hFFFF};

    packetizer_ledger ledger = new();

    cfp_stream_if #(.t_payload(t_in_item))  cmd_if ();
    cfp_stream_if #(.t_payload(t_out_item)) res_if ();

    credit_flow_packetizer_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver stalls at random according to the current mode.
    always @(posedge clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Both channels are observed at the clock edge, before any driver update lands, so
    // an item counts exactly when valid and ready were high together at that edge.
    always @(posedge clk) begin
        if (rst_n && cmd_if.valid && cmd_if.ready) ledger.note_command(cmd_if.payload);
        if (rst_n && res_if.valid && res_if.ready) ledger.check_outcome(res_if.payload);
    end

    // Offers one item, possibly after some idle cycles, and returns at the edge where it
    // is taken. Valid stays high afterwards so back-to-back items need no extra edge.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] qty);
        while ($urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= '{operation: op, amount: qty};
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // Holds the sender back until every result owed has come out.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (ledger.outstanding() != 0) @(posedge clk);
    endtask

    // Writes all three link registers on consecutive edges; the block is idle here.
    task automatic program_link(input logic [CFG_DATA_W-1:0] maxp_word,
                                input logic [CFG_DATA_W-1:0] width_word,
                                input logic [CFG_DATA_W-1:0] depth_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_PACKET;
        cfg_data  <= maxp_word;
        @(posedge clk);
        cfg_index <= CFG_BUFFER_WIDTH;
        cfg_data  <= width_word;
        @(posedge clk);
        cfg_index <= CFG_BUFFER_DEPTH;
        cfg_data  <= depth_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        ledger.set_link(maxp_word, width_word, depth_word);
    endtask

    initial begin
        int unsigned      maxp_eff, width_eff, depth_now, cap, r;
        logic [SIZE_W-1:0] qty;
        logic [OP_W-1:0]   op;

        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_MAX_PACKET;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset settings (1024-bit packets, 64-bit slots,
        // 16 credits), with both sides idling now and then.
        idle_pct  = idle_modes[3];
        stall_pct = stall_modes[3];
        send_command(OP_SERVICE, '0);   // nothing queued: no effect
        send_command(OP_NONE, '1);      // unused code is ignored
        send_command(OP_CREDIT, '1);    // credits saturate at the depth
        send_command(OP_PUSH, '0);      // zero-size message...
        send_command(OP_SERVICE, '1);   // ...is popped and retired with no packet
        // Seventeen pushes: the queue fills and the last one is dropped.
        send_command(OP_PUSH, 20'd1);
        send_command(OP_PUSH, 20'd960); // exactly one full packet of payload
        send_command(OP_PUSH, 20'd961); // one bit spills into a second packet
        send_command(OP_PUSH, '0);
        send_command(OP_PUSH, 20'd5000);
        repeat (12) send_command(OP_PUSH, SIZE_W'($urandom_range(1, 2000)));
        send_command(OP_SERVICE, '0);   // one-bit message goes out as its last packet
        send_command(OP_SERVICE, '0);   // and is retired on the next step
        send_command(OP_SERVICE, '0);   // full-size packet lacks credits and waits
        send_command(OP_CREDIT, 20'd5);
        send_command(OP_SERVICE, '0);

        for (int p = 0; p < LINK_SETTINGS; p++) begin
            wait_drained();
            program_link(maxp_words[p], width_words[p], depth_words[p]);

            // Message sizes are scaled to the payload that can actually be sent here,
            // so most messages complete and the later states get exercised.
            maxp_eff  = (maxp_words[p] < HEADER_BITS + 1) ? HEADER_BITS + 1 : maxp_words[p];
            width_eff = (width_words[p][CREDIT_W-1:0] == 0) ? 1 : width_words[p][CREDIT_W-1:0];
            depth_now = depth_words[p][CREDIT_W-1:0];
            cap = (maxp_eff < depth_now * width_eff) ? maxp_eff : depth_now * width_eff;
            cap = (cap > HEADER_BITS) ? cap - HEADER_BITS : 1;

            for (int n = 0; n < ITEMS_PER_LINK; n++) begin
                idle_pct  = idle_modes[(p + 2 * n / ITEMS_PER_LINK) % 4];
                stall_pct = stall_modes[(p + 2 * n / ITEMS_PER_LINK) % 4];
                if (n == ITEMS_PER_LINK / 2) begin
                    wait_drained();
                    // The largest message size fits well with the widest slots.
                    if (maxp_words[p] == 16'hFFFF && depth_now == 1024) send_command(OP_PUSH, '1);
                end
                r = $urandom_range(99);
                if (r < 26) begin
                    op = OP_PUSH;
                    r  = $urandom_range(99);
                    if (r < 8) qty = '0;
                    else if (r < 18) qty = SIZE_W'(cap * $urandom_range(1, 3));
                    else qty = SIZE_W'($urandom_range(1, 3 * cap));
                end else if (r < 54) begin
                    op  = OP_CREDIT;
                    qty = ($urandom_range(99) < 15) ? SIZE_W'($urandom) :
                          SIZE_W'($urandom_range(0, depth_now + 2));
                end else begin
                    op  = (r < 95) ? OP_SERVICE : OP_NONE;
                    qty = SIZE_W'($urandom);
                end
                send_command(op, qty);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);

        $display("Run covered %0d items over %0d link settings: %0d packets, %0d retired messages,",
                 ledger.commands, LINK_SETTINGS, ledger.packets, ledger.retirements);
        $display("%0d dropped pushes, %0d service steps held back for credits, %0d mismatches.",
                 ledger.drops, ledger.starved, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("PASS credit_flow_packetizer_top");
        end else begin
            $display("FAIL credit_flow_packetizer_top");
        end
        $finish;
    end

    // Safety net that lasts many times what the slowest legal run needs.
    initial begin
        #10ms;
        $display("Timeout with %0d results still owed", ledger.outstanding());
        $display("FAIL credit_flow_packetizer_top");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cfp_pkg.sv
rtl/cfp_stream_if.sv
rtl/cfp_ram.sv
rtl/cfp_front.sv
rtl/cfp_div.sv
rtl/cfp_back.sv
rtl/credit_flow_packetizer_top.sv
test/credit_flow_packetizer_top_tb.sv
